### src/aidp_pkg.sv
// Package for the ASCII decimal to 64-bit integer parser.
// Holds the transfer payload types and the character and kind codes.
// No dependencies; every module of the parser imports it.
`timescale 1ns / 1ps
`default_nettype none

package aidp_pkg;

    // Item kinds on the input channel.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Character codes.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // Accumulator widths: the product by ten needs four guard bits.
    localparam int VALUE_W = 64;
    localparam int WIDE_W  = VALUE_W + 4;

    // Input item: one character or an end marker.
    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } t_in_item;

    // Result item, emitted once per end marker.
    typedef struct packed {
        logic                ok;
        logic [VALUE_W-1:0]  value;
    } t_out_item;

    // Inputs of the digit accumulator.
    typedef struct packed {
        logic                signed_mode;
        logic                negative;
        logic [3:0]          digit;
        logic [VALUE_W-1:0]  magnitude;
    } t_acc_req;

endpackage : aidp_pkg

`default_nettype wire

### src/aidp_digit_acc.sv
// Digit accumulator: magnitude * 10 + digit with a range check.
// The check compares the widened sum against the active 64-bit limit.
// Depends on aidp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aidp_digit_acc
    import aidp_pkg::*;
(
    input  var t_acc_req             i_req,
    output var logic [VALUE_W-1:0]   o_magnitude,
    output var logic                 o_overflow
);

    logic [WIDE_W-1:0]  w_wide_mag;
    logic [WIDE_W-1:0]  w_sum;
    logic [VALUE_W-1:0] w_limit;

    // Times ten as a shift-add, then add the new digit.
    assign w_wide_mag = {4'b0000, i_req.magnitude};
    assign w_sum      = (w_wide_mag << 3) + (w_wide_mag << 1)
                        + {{(WIDE_W-4){1'b0}}, i_req.digit};

    // Largest magnitude allowed: 2^63 for negative signed, 2^63-1 for
    // positive signed, and all ones for unsigned.
    always_comb begin
        if (!i_req.signed_mode) begin
            w_limit = {VALUE_W{1'b1}};
        end else if (i_req.negative) begin
            w_limit = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            w_limit = {1'b0, {(VALUE_W-1){1'b1}}};
        end
    end

    assign o_overflow  = w_sum > {4'b0000, w_limit};
    assign o_magnitude = w_sum[VALUE_W-1:0];

endmodule : aidp_digit_acc

`default_nettype wire

### src/aidp_core.sv
// Parser core: phase, magnitude and sign registers and their update.
// Produces the result of an end item combinationally for the output register.
// Depends on aidp_pkg and aidp_digit_acc.
`timescale 1ns / 1ps
`default_nettype none

module aidp_core
    import aidp_pkg::*;
(
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    input  var logic       i_step,
    input  var t_in_item   i_item,
    input  var logic       i_signed_mode,
    output var t_out_item  o_result
);

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_SIGN  = 3'd1,
        PH_DIGIT = 3'd2,
        PH_TRAIL = 3'd3,
        PH_ERROR = 3'd4
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [VALUE_W-1:0]  r_magnitude, n_magnitude;
    logic                r_negative, n_negative;

    logic [7:0]          w_c;
    logic                w_is_digit;
    logic                w_is_ws;
    t_acc_req            w_req;
    logic [VALUE_W-1:0]  w_acc_mag;
    logic                w_acc_ovf;

    // Character classification.
    assign w_c        = i_item.char_code;
    assign w_is_digit = (w_c >= CHAR_ZERO) && (w_c <= CHAR_NINE);
    assign w_is_ws    = (w_c == CHAR_SPACE) || (w_c == CHAR_TAB) || (w_c == CHAR_LF)
                        || (w_c == CHAR_VT) || (w_c == CHAR_FF) || (w_c == CHAR_CR);

    // The low nibble of an ASCII digit is its value.
    assign w_req.signed_mode = i_signed_mode;
    assign w_req.negative    = r_negative;
    assign w_req.digit       = w_c[3:0];
    assign w_req.magnitude   = r_magnitude;

    aidp_digit_acc u_acc (
        .i_req       (w_req),
        .o_magnitude (w_acc_mag),
        .o_overflow  (w_acc_ovf)
    );

    // Next state for one transfer.
    always_comb begin
        n_phase     = r_phase;
        n_magnitude = r_magnitude;
        n_negative  = r_negative;
        if (i_step) begin
            if (i_item.kind == KIND_END) begin
                n_phase     = PH_LEAD;
                n_magnitude = '0;
                n_negative  = 1'b0;
            end else begin
                case (r_phase)
                    PH_LEAD: begin
                        if (w_is_ws) begin
                            n_phase = PH_LEAD;
                        end else if (w_c == CHAR_PLUS) begin
                            n_phase = PH_SIGN;
                        end else if (w_c == CHAR_MINUS && i_signed_mode) begin
                            n_phase    = PH_SIGN;
                            n_negative = 1'b1;
                        end else if (w_is_digit) begin
                            if (w_acc_ovf) begin
                                n_phase = PH_ERROR;
                            end else begin
                                n_phase     = PH_DIGIT;
                                n_magnitude = w_acc_mag;
                            end
                        end else begin
                            n_phase = PH_ERROR;
                        end
                    end
                    PH_SIGN, PH_DIGIT: begin
                        if (w_is_digit) begin
                            if (w_acc_ovf) begin
                                n_phase = PH_ERROR;
                            end else begin
                                n_phase     = PH_DIGIT;
                                n_magnitude = w_acc_mag;
                            end
                        end else if (r_phase == PH_DIGIT && w_is_ws) begin
                            n_phase = PH_TRAIL;
                        end else begin
                            n_phase = PH_ERROR;
                        end
                    end
                    PH_TRAIL: begin
                        if (!w_is_ws) begin
                            n_phase = PH_ERROR;
                        end
                    end
                    default: begin
                        n_phase = PH_ERROR;
                    end
                endcase
            end
        end
    end

    // Result of an end item: valid text gives the signed or plain value.
    always_comb begin
        o_result.ok    = (r_phase == PH_DIGIT) || (r_phase == PH_TRAIL);
        o_result.value = '0;
        if (o_result.ok) begin
            o_result.value = r_negative ? (~r_magnitude + 64'd1) : r_magnitude;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_magnitude <= '0;
            r_negative  <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_magnitude <= n_magnitude;
            r_negative  <= n_negative;
        end
    end

endmodule : aidp_core

`default_nettype wire

### src/ascii_decimal_int64_parser.sv
// Top level of the ASCII decimal to 64-bit integer parser.
// Input register, result register, mode register and handshakes.
// Depends on aidp_pkg and aidp_core.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes one character per cycle while o_in_stall is low and gives one
// result per end item. A character transfer is consumed from the input register
// by the core; an end item's result appears in the output register the cycle
// after the end item is consumed. The sustained rate is one item per clock while
// o_in_stall is low, set by the single update of the phase and accumulator
// registers (a 68-bit shift-add and compare).
// o_in_stall rises only when an end item waits for a result still held by
// the downstream stall. Write signed_mode (reset 1) only while the parser is
// idle; 1 parses signed 64-bit text, 0 unsigned. No clearing pass follows
// reset.
module ascii_decimal_int64_parser
    import aidp_pkg::*;
(
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    input  var logic       i_cfg_wr_en,
    input  var logic       i_cfg_wr_data,
    input  var logic       i_in_valid,
    output var logic       o_in_stall,
    input  var t_in_item   i_in_item,
    output var logic       o_out_valid,
    input  var logic       i_out_stall,
    output var t_out_item  o_out_item
);

    logic       r_signed_mode;
    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;

    logic       w_out_free;
    logic       w_step;
    logic       w_step_end;
    t_out_item  w_result;

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_signed_mode <= i_cfg_wr_data;
        end
    end

    // Characters always advance; an end item needs room in the result register.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && ((r_in_item.kind == KIND_CHAR) || w_out_free);
    assign w_step_end = w_step && (r_in_item.kind == KIND_END);
    assign o_in_stall = r_in_valid && !w_step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    aidp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_item        (r_in_item),
        .i_signed_mode (r_signed_mode),
        .o_result      (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step_end) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A rejected text always carries a zero value.
    a_reject_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.ok) |-> (r_out_item.value == '0))
        else $error("rejected result with nonzero value");

    // Every consumed end item yields a result in the next cycle.
    a_end_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step_end |=> r_out_valid)
        else $error("end item consumed without a result");

    // A stalled input item stays in the input register unchanged.
    a_hold_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> (r_in_valid && $stable(r_in_item)))
        else $error("stalled input item lost");

endmodule : ascii_decimal_int64_parser

`default_nettype wire

### sim/ascii_decimal_int64_parser_checker.sv
// Checker for the ASCII decimal to 64-bit integer parser.
// Watches the mode port and both transfer channels, predicts every result and compares it.
// Depends on aidp_pkg for the payload types and character codes.
`timescale 1ns / 1ps

module ascii_decimal_int64_parser_checker
    import aidp_pkg::*;
(
    input  var logic      i_clk,
    input  var logic      i_rst_n,
    input  var logic      i_cfg_wr_en,
    input  var logic      i_cfg_wr_data,
    input  var logic      i_in_valid,
    input  var logic      i_in_stall,
    input  var t_in_item  i_in_item,
    input  var logic      i_out_valid,
    input  var logic      i_out_stall,
    input  var t_out_item i_out_item,
    output int            o_mismatches,
    output int            o_awaiting,
    output int            o_results,
    output int            o_numbers
);

    localparam int MAX_REPORTS = 10;

    // Magnitude limits for positive signed, negative signed and unsigned text.
    localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] UNS_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        SCAN_LEAD,
        SCAN_SIGN,
        SCAN_DIGITS,
        SCAN_TRAIL,
        SCAN_BAD
    } t_scan;

    // Shadow copy of the mode register and of the text being parsed.
    logic        mode_signed = 1'b1;
    t_scan       scan        = SCAN_LEAD;
    logic [63:0] magnitude   = '0;
    logic        negative    = 1'b0;

    // Results predicted but not yet seen on the output channel.
    t_out_item   parsed_results[$];

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR};
    endfunction

    // Adds one digit unless that would push the magnitude past the current limit.
    task automatic add_digit(input logic [3:0] d);
        logic [63:0] limit;
        limit = !mode_signed ? UNS_LIMIT : (negative ? NEG_LIMIT : POS_LIMIT);
        if (magnitude > (limit - 64'(d)) / 64'd10) begin
            scan = SCAN_BAD;
        end else begin
            magnitude = magnitude * 64'd10 + 64'(d);
            scan = SCAN_DIGITS;
        end
    endtask

    task automatic add_char(input logic [7:0] c);
        logic is_digit;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        case (scan)
            SCAN_LEAD: begin
                if (!is_blank(c)) begin
                    if (c == CHAR_PLUS) begin
                        scan = SCAN_SIGN;
                    end else if (c == CHAR_MINUS && mode_signed) begin
                        negative = 1'b1;
                        scan = SCAN_SIGN;
                    end else if (is_digit) begin
                        add_digit(c[3:0]);
                    end else begin
                        scan = SCAN_BAD;
                    end
                end
            end
            SCAN_SIGN, SCAN_DIGITS: begin
                if (is_digit) begin
                    add_digit(c[3:0]);
                end else if (scan == SCAN_DIGITS && is_blank(c)) begin
                    scan = SCAN_TRAIL;
                end else begin
                    scan = SCAN_BAD;
                end
            end
            SCAN_TRAIL: begin
                if (!is_blank(c)) begin
                    scan = SCAN_BAD;
                end
            end
            default: begin
                scan = SCAN_BAD;
            end
        endcase
    endtask

    // The end marker yields one result and clears the text state.
    task automatic finish_text();
        t_out_item res;
        res.ok    = (scan == SCAN_DIGITS) || (scan == SCAN_TRAIL);
        res.value = res.ok ? (negative ? -magnitude : magnitude) : '0;
        parsed_results.push_back(res);
        scan      = SCAN_LEAD;
        magnitude = '0;
        negative  = 1'b0;
    endtask

    // Everything is sampled at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            mode_signed = 1'b1;
            scan        = SCAN_LEAD;
            magnitude   = '0;
            negative    = 1'b0;
            parsed_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                mode_signed = i_cfg_wr_data;
            end

            // Input transfer: advance the prediction.
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.kind == KIND_END) begin
                    finish_text();
                end else begin
                    add_char(i_in_item.char_code);
                end
            end

            // Output transfer: compare with the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (parsed_results.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= MAX_REPORTS) begin
                        $display("%0t: result with none predicted: ok=%0b value=%h",
                                 $realtime, i_out_item.ok, i_out_item.value);
                    end
                end else begin
                    want = parsed_results.pop_front();
                    if (want.ok) begin
                        o_numbers++;
                    end
                    if (i_out_item.ok !== want.ok || i_out_item.value !== want.value) begin
                        o_mismatches++;
                        if (o_mismatches <= MAX_REPORTS) begin
                            $display("%0t: result %0d: expected ok=%0b value=%h, got ok=%0b value=%h",
                                     $realtime, o_results, want.ok, want.value,
                                     i_out_item.ok, i_out_item.value);
                        end
                    end
                end
            end
        end
        o_awaiting = parsed_results.size();
    end

endmodule : ascii_decimal_int64_parser_checker

### sim/ascii_decimal_int64_parser_tb.sv
// Testbench top for the ASCII decimal to 64-bit integer parser.
// Drives text fields and mode writes, stalls the result side and gives the verdict.
// Depends on aidp_pkg, ascii_decimal_int64_parser and ascii_decimal_int64_parser_checker.
`timescale 1ns / 1ps

module ascii_decimal_int64_parser_tb;
    import aidp_pkg::*;

    localparam int ITEM_TARGET    = 1350;
    localparam int IDLE_PCT       = 18;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      in_valid    = 1'b0;
    t_in_item  in_item     = '0;
    logic      out_stall   = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    int mismatches;
    int awaiting;
    int results;
    int numbers;

    int   in_taken     = 0;
    int   items_sent   = 0;
    int   texts_sent   = 0;
    int   stuck_cycles = 0;
    logic steady_run   = 1'b0;
    logic mode_now     = 1'b1;

    // Characters of the text field under construction.
    logic [7:0] field_chars[$];

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    ascii_decimal_int64_parser u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_item     (in_item),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_item    (out_item)
    );

    ascii_decimal_int64_parser_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .o_mismatches  (mismatches),
        .o_awaiting    (awaiting),
        .o_results     (results),
        .o_numbers     (numbers)
    );

    // Random stall on the result side, off during the steady stretch.
    always @(negedge clk) begin
        out_stall <= steady_run ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end

    // Count input transfers so the driver can wait on them at the falling edge.
    always @(posedge clk) begin
        if (in_valid && !in_stall) begin
            in_taken <= in_taken + 1;
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles.", stuck_cycles);
                $display("ascii_decimal_int64_parser test failed");
                $finish;
            end
        end
    end

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 5))
            0:       return CHAR_SPACE;
            1:       return CHAR_TAB;
            2:       return CHAR_LF;
            3:       return CHAR_VT;
            4:       return CHAR_FF;
            default: return CHAR_CR;
        endcase
    endfunction

    // One input transfer, with an optional idle gap in front of it.
    task automatic send_item(input logic kind, input logic [7:0] code);
        int       target;
        t_in_item item;
        if (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        item.kind      = kind;
        item.char_code = code;
        target         = in_taken + 1;
        in_valid      <= 1'b1;
        in_item       <= item;
        items_sent++;
        do @(negedge clk); while (in_taken != target);
    endtask

    // Hold the sender until every predicted result has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (awaiting != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_mode(input logic signed_text);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= signed_text;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        mode_now     = signed_text;
    endtask

    // Sends the field and its end marker; the mode may flip partway through.
    task automatic send_text(input int flip_at);
        for (int i = 0; i < field_chars.size(); i++) begin
            if (i == flip_at) begin
                set_mode(!mode_now);
            end
            send_item(KIND_CHAR, field_chars[i]);
        end
        send_item(KIND_END, 8'($urandom));
        texts_sent++;
    endtask

    task automatic add_str(input string s);
        foreach (s[i]) begin
            field_chars.push_back(s[i]);
        end
    endtask

    task automatic send_str(input string s);
        field_chars.delete();
        add_str(s);
        send_text(-1);
    endtask

    // A well-formed number, often right at or just past the limit of the mode.
    task automatic build_number();
        logic [67:0] num;
        logic [67:0] limit;
        logic        minus;
        int          sel;
        minus = 1'b0;
        field_chars.delete();
        repeat ($urandom_range(0, 2)) field_chars.push_back(random_blank());

        // Minus also shows up now and then in unsigned mode, where it is rejected.
        sel = $urandom_range(0, 5);
        if (sel == 2) begin
            field_chars.push_back(CHAR_PLUS);
        end else if ((sel >= 3 && sel <= 4 && mode_now) || sel == 5) begin
            field_chars.push_back(CHAR_MINUS);
            minus = 1'b1;
        end

        if (!mode_now) begin
            limit = 68'h0_FFFF_FFFF_FFFF_FFFF;
        end else begin
            limit = minus ? 68'h0_8000_0000_0000_0000 : 68'h0_7FFF_FFFF_FFFF_FFFF;
        end

        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            num = 68'($urandom_range(0, 99999));
        end else if (sel < 7) begin
            num = 68'({$urandom, $urandom} >> $urandom_range(0, 63));
        end else begin
            num = limit + 68'($urandom_range(0, 6)) - 68'd3;
        end

        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) field_chars.push_back(CHAR_ZERO);
        end
        add_str($sformatf("%0d", num));
        repeat ($urandom_range(0, 2)) field_chars.push_back(random_blank());
    endtask

    // Malformed fields: empty, noise, a corrupted byte, inner blanks, stray signs.
    task automatic build_broken();
        int sel;
        sel = $urandom_range(0, 5);
        if (sel == 0) begin
            field_chars.delete();
            repeat ($urandom_range(0, 3)) field_chars.push_back(random_blank());
        end else if (sel == 1) begin
            field_chars.delete();
            repeat ($urandom_range(1, 6)) field_chars.push_back(8'($urandom));
        end else if (sel == 5) begin
            field_chars.delete();
            field_chars.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            repeat ($urandom_range(0, 1)) field_chars.push_back(random_blank());
        end else begin
            build_number();
            if (sel == 2) begin
                field_chars[$urandom_range(0, field_chars.size() - 1)] = 8'($urandom);
            end else if (sel == 3) begin
                field_chars.insert($urandom_range(0, field_chars.size()), random_blank());
            end else begin
                field_chars.insert($urandom_range(0, field_chars.size()),
                                   $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            end
        end
    endtask

    initial begin
        int flip_at;
        int goal;

        // Synchronous reset, released at a falling edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed fields in signed mode: empty and all-blank text.
        send_str("");
        field_chars = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR};
        send_text(-1);

        // A lone sign, and a blank right after a sign.
        send_str("+");
        field_chars = '{CHAR_MINUS, CHAR_TAB};
        add_str("5");
        send_text(-1);

        // A second sign and a sign after digits.
        send_str("+-1");
        send_str("7-");

        // Byte extremes: a null character, then a digit followed by 0xFF.
        field_chars = '{8'h00};
        send_text(-1);
        field_chars.delete();
        add_str("1");
        field_chars.push_back(8'hFF);
        send_text(-1);

        // A blank between digits, and negative zero.
        send_str("4 2");
        send_str("-0");

        // Unsigned mode rejects minus and still takes plus.
        set_mode(1'b0);
        send_str("-3");
        send_str("+9");

        // Random part in four stretches: unsigned, signed, unsigned without idling, signed.
        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) begin
                set_mode(ph % 2 == 1);
            end
            steady_run = (ph == 2);
            goal = (ph + 1) * ITEM_TARGET / 4;
            while (items_sent < goal) begin
                if ($urandom_range(0, 3) == 0) begin
                    build_broken();
                end else begin
                    build_number();
                end
                // Now and then the mode changes in the middle of a field.
                flip_at = -1;
                if ($urandom_range(0, 39) == 0 && field_chars.size() > 1) begin
                    flip_at = field_chars.size() / 2;
                end
                send_text(flip_at);
            end
        end
        steady_run = 1'b0;

        drain_results();

        $display("Sent %0d text fields in %0d transfers, in signed and unsigned mode.",
                 texts_sent, items_sent);
        $display("Checked %0d results, %0d of them valid numbers; %0d mismatches.",
                 results, numbers, mismatches);
        if (mismatches == 0 && awaiting == 0) begin
            $display("ascii_decimal_int64_parser test passed");
        end else begin
            $display("ascii_decimal_int64_parser test failed");
        end
        $finish;
    end

endmodule : ascii_decimal_int64_parser_tb
